FILE: hw/rtl/dssm_pkg.sv
// drum step sequencer package: sizes, opcodes, controller states, command/status types
// no dependencies
`timescale 1ns / 1ps
package dssm_pkg;
  localparam int TRACKS = 7;
  localparam int MAX_STEPS = 64;
  localparam int SAMPLE_DEPTH = 4096;
  localparam int TRK_W = 3;
  localparam int STEP_W = 6;
  localparam int ADDR_W = 12;
  localparam int LEN_W = 13;
  localparam int POS_W = 23;
  localparam int SUM_W = 24;
  localparam int ACC_W = 26;
  localparam int MEM_AW = TRK_W + ADDR_W;
  localparam int MEM_DEPTH = TRACKS * SAMPLE_DEPTH;

  localparam logic [2:0] OP_WRITE_SAMPLE = 3'd0;
  localparam logic [2:0] OP_SET_LENGTH   = 3'd1;
  localparam logic [2:0] OP_WRITE_STEP   = 3'd2;
  localparam logic [2:0] OP_TICK         = 3'd3;
  localparam logic [2:0] OP_RESTART      = 3'd4;

  localparam logic REG_STEP_LENGTH = 1'b0;
  localparam logic REG_STEP_COUNT  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_SCAN, S_DRAIN, S_FINISH, S_OUT
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic do_write;   // apply a non-tick request
    logic start_tick; // load tick compare values, clear accumulator
    logic scan;       // evaluate one (track, step) pair
    logic finish;     // saturate, update position, load output
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;  // last pair issued this cycle
    logic pipe_empty; // no memory read in flight
  } dp_status_t;
endpackage

FILE: hw/rtl/dssm_if.sv
// valid/ready channel interface carrying one request or result
// depends on nothing
`timescale 1ns / 1ps
interface dssm_in_if;
  logic valid;
  logic ready;
  logic [2:0] opcode;
  logic [2:0] track;
  logic [11:0] sample_address;
  logic signed [15:0] sample_value;
  logic [12:0] sample_length;
  logic [5:0] step_index;
  logic hit;
  modport source (output valid, opcode, track, sample_address, sample_value,
                  sample_length, step_index, hit, input ready);
  modport sink (input valid, opcode, track, sample_address, sample_value,
                sample_length, step_index, hit, output ready);
endinterface

interface dssm_out_if;
  logic valid;
  logic ready;
  logic signed [23:0] mix_sample;
  logic last;
  modport source (output valid, mix_sample, last, input ready);
  modport sink (input valid, mix_sample, last, output ready);
endinterface

FILE: hw/rtl/drum_step_sequencer_mixer.sv
// drum step sequencer mixer top level: channels, apb registers, controller, datapath
// depends on dssm_pkg, dssm_if, dssm_ctrl, dssm_dp
//
// usage: requests arrive on in_ch (opcode 0..2 load samples, lengths and
// pattern steps, 3 ticks, 4 restarts the render). each tick returns one
// mix_sample on out_ch, the saturated sum of every sounding hit at the
// current render position; last marks the final sample and stays high.
// step_length and step_count sit at apb byte addresses 0 and 4.
// a tick scans all 7 x 64 track/step pairs, one pair a cycle through the
// single sample ram read port; the result is offered after the scan, the
// last ram read and the finish step, and stays offered until it is taken.
// while the result waits, no request is taken. reset clears lengths,
// pattern, position and sets registers to step_length 5512,
// step_count 16; sample ram contents are undefined.
`timescale 1ns / 1ps
module drum_step_sequencer_mixer (
  input  logic clk,
  input  logic rst,
  dssm_in_if.sink in_ch,
  dssm_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import dssm_pkg::*;

  dp_cmd_t cmd;
  dp_status_t status;
  logic cfg_we;
  logic [15:0] step_length;
  logic [6:0] step_count;

  // apb register access
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_STEP_LENGTH: prdata = {16'd0, step_length};
      REG_STEP_COUNT:  prdata = {25'd0, step_count};
      default: prdata = '0;
    endcase
  end

  dssm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_opcode(in_ch.opcode),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .status(status)
  );

  dssm_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_opcode(in_ch.opcode), .in_track(in_ch.track),
    .in_sample_address(in_ch.sample_address), .in_sample_value(in_ch.sample_value),
    .in_sample_length(in_ch.sample_length), .in_step_index(in_ch.step_index),
    .in_hit(in_ch.hit), .cfg_we(cfg_we),
    .cfg_sel(paddr[2]), .cfg_wdata(pwdata), .step_length(step_length),
    .step_count(step_count), .mix_sample(out_ch.mix_sample), .last(out_ch.last)
  );
endmodule

FILE: hw/rtl/dssm_ram.sv
// generic single port write, single port registered read ram
// no dependencies
`timescale 1ns / 1ps
module dssm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/dssm_ctrl.sv
// controller state machine for request handling and tick scanning
// depends on dssm_pkg
`timescale 1ns / 1ps
module dssm_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [2:0] in_opcode,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output dssm_pkg::dp_cmd_t cmd,
  input  dssm_pkg::dp_status_t status
);
  import dssm_pkg::*;

  ctrl_state_t state, state_next;
  logic take;

  assign take = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (take && in_opcode == OP_TICK) state_next = S_SETUP;
      S_SETUP:  state_next = S_SCAN;
      S_SCAN:   if (status.scan_done) state_next = S_DRAIN;
      S_DRAIN:  if (status.pipe_empty) state_next = S_FINISH;
      S_FINISH: state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    out_valid = 1'b0;
    cmd = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.do_write = take && in_opcode != OP_TICK;
        cmd.start_tick = take && in_opcode == OP_TICK;
      end
      S_SCAN:   cmd.scan = 1'b1;
      S_FINISH: cmd.finish = 1'b1;
      S_OUT:    out_valid = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a result is only offered after a finish cycle
  a_out_after_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish)) else $error("result without finish");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("request taken while busy");
  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && status.scan_done) |=> state == S_DRAIN)
    else $error("scan did not end");
endmodule

FILE: hw/rtl/dssm_dp.sv
// datapath: registers, track lengths, pattern bits, sample ram, mix accumulator
// depends on dssm_pkg and dssm_ram
`timescale 1ns / 1ps
module dssm_dp (
  input  logic clk,
  input  logic rst,
  input  dssm_pkg::dp_cmd_t cmd,
  output dssm_pkg::dp_status_t status,
  input  logic [2:0] in_opcode,
  input  logic [2:0] in_track,
  input  logic [11:0] in_sample_address,
  input  logic [15:0] in_sample_value,
  input  logic [12:0] in_sample_length,
  input  logic [5:0] in_step_index,
  input  logic in_hit,
  input  logic cfg_we,
  input  logic cfg_sel,
  input  logic [31:0] cfg_wdata,
  output logic [15:0] step_length,
  output logic [6:0] step_count,
  output logic signed [23:0] mix_sample,
  output logic last
);
  import dssm_pkg::*;

  logic [LEN_W-1:0] track_length [TRACKS];
  logic [MAX_STEPS-1:0] pattern [TRACKS];
  logic [POS_W-1:0] position;

  // tick working registers
  logic [6:0] steps_eff;
  logic [6:0] steps_cap;
  logic [LEN_W-1:0] longest;
  logic [POS_W:0] total;
  logic [TRK_W-1:0] scan_trk;
  logic [STEP_W-1:0] scan_step;
  logic [POS_W:0] start;       // scan_step * step_length, kept incrementally
  logic in_range;
  logic rd_pend;
  logic signed [ACC_W-1:0] acc;
  logic [15:0] rdata;
  logic [MEM_AW-1:0] raddr;
  logic [LEN_W-1:0] off;
  logic [POS_W:0] diff;
  logic pair_hit;
  logic last_pair;
  logic ram_we;

  // effective step count and longest loaded length (comparison chain over tracks)
  always_comb begin
    longest = '0;
    for (int i = 0; i < TRACKS; i++) begin
      if (track_length[i] > longest) longest = track_length[i];
    end
  end
  assign steps_cap = (step_count > 7'(MAX_STEPS)) ? 7'(MAX_STEPS) : step_count;

  // per pair evaluation
  assign diff = {1'b0, position} - start;
  assign off = diff[LEN_W-1:0];
  assign pair_hit = pattern[scan_trk][scan_step] && ({1'b0, position} >= start)
                    && (diff < {{(POS_W+1-LEN_W){1'b0}}, track_length[scan_trk]})
                    && ({1'b0, scan_step} < steps_eff) && in_range;
  assign raddr = {scan_trk, off[ADDR_W-1:0]};
  assign last_pair = (scan_trk == TRK_W'(TRACKS-1)) && (scan_step == STEP_W'(MAX_STEPS-1));
  assign status.scan_done = cmd.scan && last_pair;
  assign status.pipe_empty = !rd_pend;
  assign ram_we = cmd.do_write && in_opcode == OP_WRITE_SAMPLE
                  && in_track < TRK_W'(TRACKS);

  dssm_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr({in_track, in_sample_address}),
    .wdata(in_sample_value), .raddr(raddr), .rdata(rdata)
  );

  // configuration and request state
  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= 16'd5512;
      step_count <= 7'd16;
      position <= '0;
      for (int i = 0; i < TRACKS; i++) begin
        track_length[i] <= '0;
        pattern[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_sel == REG_STEP_LENGTH) step_length <= cfg_wdata[15:0];
        else step_count <= cfg_wdata[6:0];
      end
      if (cmd.do_write && in_track < TRK_W'(TRACKS)) begin
        if (in_opcode == OP_SET_LENGTH) begin
          track_length[in_track] <= (in_sample_length > LEN_W'(SAMPLE_DEPTH))
                                    ? LEN_W'(SAMPLE_DEPTH) : in_sample_length;
        end
        if (in_opcode == OP_WRITE_STEP) pattern[in_track][in_step_index] <= in_hit;
      end
      if (cmd.do_write && in_opcode == OP_RESTART) position <= '0;
      if (cmd.finish && in_range) position <= position + 1'b1;
    end
  end

  // tick scan: one (track, step) pair a cycle, step offset accumulated
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.scan && pair_hit;
    end
    if (cmd.start_tick) begin
      steps_eff <= steps_cap;
      scan_trk <= '0;
      scan_step <= '0;
      start <= '0;
      acc <= '0;
    end else begin
      if (cmd.scan) begin
        if (scan_step == STEP_W'(MAX_STEPS-1)) begin
          scan_step <= '0;
          start <= '0;
          scan_trk <= scan_trk + 1'b1;
        end else begin
          scan_step <= scan_step + 1'b1;
          start <= start + {{(POS_W-15){1'b0}}, step_length};
        end
      end
      if (rd_pend) acc <= acc + ACC_W'($signed(rdata));
    end
  end

  // render length: steps_eff * step_length + longest, loaded with the tick request
  always_ff @(posedge clk) begin
    if (cmd.start_tick) begin
      total <= ({{(POS_W-6){1'b0}}, steps_cap} * {{(POS_W-15){1'b0}}, step_length})
               + {{(POS_W+1-LEN_W){1'b0}}, longest};
    end
  end
  assign in_range = {1'b0, position} < total;

  // saturate and load the result
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (!in_range) mix_sample <= '0;
      else if (acc > ACC_W'(8388607)) mix_sample <= 24'sh7FFFFF;
      else if (acc < -ACC_W'(8388608)) mix_sample <= 24'sh800000;
      else mix_sample <= acc[SUM_W-1:0];
      last <= !in_range || ({1'b0, position} + 1'b1 == total);
    end
  end

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.do_write |=> track_length[0] <= LEN_W'(SAMPLE_DEPTH)) else $error("length cap");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.finish) && $past(in_range) |-> position == $past(position) + 1'b1)
    else $error("position step");
  a_scan_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.do_write |-> !cmd.scan) else $error("write during scan");
endmodule

FILE: tb/testbench.sv
// self-checking testbench for the drum step sequencer mixer
// depends on dssm_pkg, dssm_if and the drum_step_sequencer_mixer top level
`timescale 1ns / 1ps
module testbench;
  import dssm_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int TICK_LATENCY = 460;
  localparam int SAFE_WORDS = 40;
  localparam logic [2:0] OP_SPARE = OP_RESTART + 3'd1;

  typedef struct {
    logic [2:0] opcode;
    logic [2:0] track;
    logic [11:0] sample_address;
    logic signed [15:0] sample_value;
    logic [12:0] sample_length;
    logic [5:0] step_index;
    logic hit;
  } drum_req_t;

  typedef struct {
    logic signed [23:0] mix_sample;
    logic last;
  } mix_out_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  dssm_in_if in_ch ();
  dssm_out_if out_ch ();

  drum_step_sequencer_mixer dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the block state
  logic [15:0] voice_mem [MEM_DEPTH];
  logic [12:0] voice_len [TRACKS];
  bit hit_map [TRACKS][MAX_STEPS];
  int unsigned play_pos;
  int unsigned cur_step_length;
  int unsigned cur_step_count;

  drum_req_t pending_reqs[$];
  mix_out_t expected_mix[$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;
  bit apb_done;

  // generator bookkeeping that keeps sample reads inside written words
  int gen_pos;
  bit long_voice [TRACKS];

  // clock, reset and initial drive
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_RESTART;
    in_ch.track = '0;
    in_ch.sample_address = '0;
    in_ch.sample_value = '0;
    in_ch.sample_length = '0;
    in_ch.step_index = '0;
    in_ch.hit = 1'b0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    forever #10 clk = ~clk;
  end

  // mix prediction for one tick
  function automatic mix_out_t predict_mix();
    mix_out_t res;
    longint sum;
    int unsigned total, longest, steps, start, off;
    longest = 0;
    for (int tr = 0; tr < TRACKS; tr++)
      if (voice_len[tr] > longest) longest = voice_len[tr];
    steps = (cur_step_count > MAX_STEPS) ? MAX_STEPS : cur_step_count;
    total = steps * cur_step_length + longest;
    sum = 0;
    res.last = 1'b1;
    if (play_pos < total) begin
      for (int tr = 0; tr < TRACKS; tr++)
        for (int k = 0; k < steps; k++) begin
          start = k * cur_step_length;
          if (hit_map[tr][k] && play_pos >= start) begin
            off = play_pos - start;
            if (off < voice_len[tr])
              sum += longint'($signed(voice_mem[tr * SAMPLE_DEPTH + off]));
          end
        end
      if (sum > 8388607) sum = 8388607;
      if (sum < -8388608) sum = -8388608;
      res.last = (play_pos + 1 == total);
      play_pos = (play_pos + 1) & 32'h7FFFFF;
    end
    res.mix_sample = sum[23:0];
    return res;
  endfunction

  // apply one accepted request to the shadow state
  function automatic void apply_request(drum_req_t r);
    case (r.opcode)
      OP_WRITE_SAMPLE: begin
        if (r.track < TRACKS)
          voice_mem[r.track * SAMPLE_DEPTH + r.sample_address] = r.sample_value;
      end
      OP_SET_LENGTH: begin
        if (r.track < TRACKS)
          voice_len[r.track] = (r.sample_length > SAMPLE_DEPTH) ? 13'(SAMPLE_DEPTH)
                                                                : r.sample_length;
      end
      OP_WRITE_STEP: begin
        if (r.track < TRACKS) hit_map[r.track][r.step_index] = r.hit;
      end
      OP_TICK: expected_mix.push_back(predict_mix());
      OP_RESTART: play_pos = 0;
      default: ;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drum_req_t r;
        r = pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.opcode <= r.opcode;
        in_ch.track <= r.track;
        in_ch.sample_address <= r.sample_address;
        in_ch.sample_value <= r.sample_value;
        in_ch.sample_length <= r.sample_length;
        in_ch.step_index <= r.step_index;
        in_ch.hit <= r.hit;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver back-pressure
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // request monitor feeds the predictor
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      drum_req_t r;
      r.opcode = in_ch.opcode;
      r.track = in_ch.track;
      r.sample_address = in_ch.sample_address;
      r.sample_value = in_ch.sample_value;
      r.sample_length = in_ch.sample_length;
      r.step_index = in_ch.step_index;
      r.hit = in_ch.hit;
      apply_request(r);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_mix.size() == 0) begin
        if (errors < 10)
          $display("unexpected result mix_sample=%0d last=%0b",
                   out_ch.mix_sample, out_ch.last);
        errors++;
      end else begin
        mix_out_t e;
        e = expected_mix.pop_front();
        if (e.mix_sample !== out_ch.mix_sample || e.last !== out_ch.last) begin
          if (errors < 10)
            $display("result error: expected mix_sample=%0d last=%0b, got %0d %0b",
                     e.mix_sample, e.last, out_ch.mix_sample, out_ch.last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || apb_done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("drum_step_sequencer_mixer: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // register write over apb, only while idle
  task automatic apb_write(logic reg_idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    apb_done <= 1'b1;
    if (reg_idx == REG_STEP_LENGTH) cur_step_length = value[15:0];
    else cur_step_count = value[6:0];
    @(posedge clk);
    apb_done <= 1'b0;
  endtask

  task automatic set_rate(int unsigned sl, int unsigned sc);
    apb_write(REG_STEP_LENGTH, sl);
    apb_write(REG_STEP_COUNT, sc);
  endtask

  function automatic drum_req_t random_req(logic [2:0] op, int tr);
    drum_req_t r;
    r.opcode = op;
    r.track = 3'(tr);
    r.sample_address = 12'($urandom);
    r.sample_value = 16'($urandom);
    r.sample_length = 13'($urandom);
    r.step_index = 6'($urandom);
    r.hit = 1'($urandom);
    return r;
  endfunction

  task automatic push_sample(int tr, int addr, int val);
    drum_req_t r;
    r = random_req(OP_WRITE_SAMPLE, tr);
    r.sample_address = 12'(addr);
    r.sample_value = 16'(val);
    pending_reqs.push_back(r);
  endtask

  task automatic push_length(int tr, int len);
    drum_req_t r;
    r = random_req(OP_SET_LENGTH, tr);
    r.sample_length = 13'(len);
    if (tr < TRACKS) long_voice[tr] = (r.sample_length > SAFE_WORDS);
    pending_reqs.push_back(r);
  endtask

  task automatic push_step(int tr, int idx, bit h);
    drum_req_t r;
    r = random_req(OP_WRITE_STEP, tr);
    r.step_index = 6'(idx);
    r.hit = h;
    pending_reqs.push_back(r);
  endtask

  task automatic push_restart();
    pending_reqs.push_back(random_req(OP_RESTART, $urandom_range(7)));
    gen_pos = 0;
  endtask

  // a tick, preceded by a restart when a long sample could reach unwritten words
  task automatic push_tick();
    bit any_long;
    any_long = 0;
    for (int tr = 0; tr < TRACKS; tr++) any_long |= long_voice[tr];
    if (any_long && gen_pos >= SAFE_WORDS - 4) push_restart();
    pending_reqs.push_back(random_req(OP_TICK, $urandom_range(7)));
    gen_pos++;
  endtask

  // random traffic with mostly well-formed requests
  task automatic push_random(int n, int restart_pct, int len_max);
    int sel, v;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        push_tick();
      end else if (sel < 60) begin
        v = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 32767 : -32768)
                                     : $urandom_range(65535);
        push_sample($urandom_range(TRACKS - 1),
                    ($urandom_range(9) < 7) ? $urandom_range(SAFE_WORDS - 1)
                                            : $urandom_range(SAMPLE_DEPTH - 1), v);
      end else if (sel < 70) begin
        v = $urandom_range(19);
        push_length($urandom_range(TRACKS - 1),
                    (v == 0) ? $urandom_range(8191) :
                    (v == 1) ? SAMPLE_DEPTH : $urandom_range(len_max));
      end else if (sel < 85) begin
        push_step($urandom_range(TRACKS - 1), $urandom_range(MAX_STEPS - 1),
                  $urandom_range(1));
      end else if (sel < 85 + restart_pct) begin
        push_restart();
      end else if ($urandom_range(1)) begin
        pending_reqs.push_back(random_req(OP_SPARE + 3'($urandom_range(2)),
                                          $urandom_range(7)));
      end else begin
        pending_reqs.push_back(random_req(3'($urandom_range(2)), TRACKS));
      end
    end
  endtask

  // let all requests drain and all results return
  task automatic drain();
    @(posedge clk);
    while (pending_reqs.size() > 0 || in_ch.valid || expected_mix.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // stimulus phases
  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    apb_done = 1'b0;
    gen_pos = 0;
    play_pos = 0;
    cur_step_length = 5512;
    cur_step_count = 16;
    for (int tr = 0; tr < TRACKS; tr++) begin
      voice_len[tr] = '0;
      long_voice[tr] = 0;
      for (int k = 0; k < MAX_STEPS; k++) hit_map[tr][k] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: defaults, spare opcodes, out-of-range track, extremes
    push_tick();
    for (int op = OP_SPARE; op <= 7; op++) pending_reqs.push_back(random_req(3'(op), 0));
    for (int op = OP_WRITE_SAMPLE; op <= OP_WRITE_STEP; op++)
      pending_reqs.push_back(random_req(3'(op), TRACKS));
    push_sample(6, SAMPLE_DEPTH - 1, -32768);
    push_sample(0, SAMPLE_DEPTH - 1, 32767);
    push_length(0, 8191);
    push_length(0, 0);
    push_step(6, MAX_STEPS - 1, 1);
    push_step(6, MAX_STEPS - 1, 0);
    push_restart();
    push_tick();
    // fill the low words of every track at full positive scale
    for (int tr = 0; tr < TRACKS; tr++)
      for (int a = 0; a < SAFE_WORDS; a++) push_sample(tr, a, 32767);
    drain();

    // positive saturation: many steps of every track overlapping
    set_rate(1, MAX_STEPS);
    for (int tr = 0; tr < TRACKS; tr++) begin
      push_length(tr, SAFE_WORDS);
      for (int k = 0; k < SAFE_WORDS; k++) push_step(tr, k, 1);
    end
    push_restart();
    repeat (45) push_tick();
    drain();

    // negative saturation across all tracks
    for (int tr = 0; tr < TRACKS; tr++)
      for (int a = 0; a < SAFE_WORDS; a++) push_sample(tr, a, -32768);
    push_restart();
    repeat (45) push_tick();
    drain();

    // empty render, then sender gaps
    set_rate(200, 0);
    for (int tr = 0; tr < TRACKS; tr++) push_length(tr, 0);
    push_restart();
    repeat (3) push_tick();
    send_idle_pct = 56;
    push_random(45, 3, SAFE_WORDS);
    drain();

    // longest steps, count above the step limit, receiver stalls
    send_idle_pct = 0;
    recv_stall_pct = 56;
    set_rate(65535, 127);
    push_random(45, 3, SAFE_WORDS);
    drain();

    // short render that reaches its end, both sides idling
    send_idle_pct = 14;
    recv_stall_pct = 14;
    set_rate(1, 2);
    push_random(45, 1, 12);
    drain();

    // random rate, no idling
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_rate($urandom_range(1, 8), $urandom_range(1, MAX_STEPS));
    push_random(45, 2, SAFE_WORDS);
    drain();

    // mixed idling with a random step length
    send_idle_pct = 56;
    recv_stall_pct = 56;
    set_rate($urandom_range(1, 65535), $urandom_range(0, 127));
    push_random(40, 3, SAFE_WORDS);
    drain();

    repeat (TICK_LATENCY) @(posedge clk);
    if (errors == 0 && expected_mix.size() == 0) begin
      $display("drum_step_sequencer_mixer: match");
    end else begin
      $display("drum_step_sequencer_mixer: mismatch");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/dssm_pkg.sv
hw/rtl/dssm_if.sv
hw/rtl/dssm_ram.sv
hw/rtl/dssm_ctrl.sv
hw/rtl/dssm_dp.sv
hw/rtl/drum_step_sequencer_mixer.sv
tb/testbench.sv
